>>> rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// shared types, widths and codes of the trapezoidal step ramp generator
// ----------------------------------------------------------------------------
package tsr_pkg;

   localparam int SPEED_FRAC_BITS = 8;
   localparam int MIN_INTERVAL    = 2;

   localparam int SPD_IN_W = 13;                          // speed registers
   localparam int SPEED_W  = SPD_IN_W + SPEED_FRAC_BITS;  // fixed point speed
   localparam int RATE_W   = 16;                          // acceleration, tick rate
   localparam int DIV_W    = RATE_W + 2 * SPEED_FRAC_BITS; // dividend width
   localparam int INTV_W   = 24;
   localparam int CNT_W    = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_MOVE   = 3'd1;
   localparam logic [2:0] OP_JOG    = 3'd2;
   localparam logic [2:0] OP_STOP   = 3'd3;
   localparam logic [2:0] OP_SETPOS = 3'd4;
   localparam logic [2:0] OP_GOTO   = 3'd5;
   localparam logic [2:0] OP_SPEED  = 3'd6;

   localparam logic [2:0] REG_START_SPEED = 3'd0;
   localparam logic [2:0] REG_HOME_SPEED  = 3'd1;
   localparam logic [2:0] REG_SPEED_CAP   = 3'd2;
   localparam logic [2:0] REG_ACCEL       = 3'd3;
   localparam logic [2:0] REG_TICK_RATE   = 3'd4;

   localparam logic [CNT_W-1:0] JOG_COUNT = 32'h7FFF_FFFF;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [SPEED_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // speed register of zero acts as one, then scaled to fixed point
   function automatic logic [SPEED_W-1:0] to_fixed(input logic [SPD_IN_W-1:0] v);
      logic [SPD_IN_W-1:0] one_min;
      one_min = (v == '0) ? SPD_IN_W'(1) : v;
      return {one_min, {SPEED_FRAC_BITS{1'b0}}};
   endfunction

endpackage

>>> rtl/tsr_div.sv
// ----------------------------------------------------------------------------
// tsr_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tsr_div (
   input  logic                clock,
   input  logic                reset,
   input  tsr_pkg::div_req_type req,
   output tsr_pkg::div_rsp_type rsp
);
   import tsr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [SPEED_W:0]     rem_ff, rem_in;
   logic [SPEED_W-1:0]   dsr_ff, dsr_in;
   logic [SPEED_W:0]     shifted;
   logic [SPEED_W+1:0]   trial;

   always_comb begin
      shifted = {rem_ff[SPEED_W-1:0], quo_ff[DIV_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         dsr_in = req.divisor;
         quo_in = req.dividend;
         rem_in = '0;
         cnt_in = '0;
         // divide by zero returns the dividend
         if (req.divisor == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial[SPEED_W+1]) begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in = trial[SPEED_W:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");

endmodule

>>> rtl/trapezoidal_step_ramp_generator_top.sv
// ----------------------------------------------------------------------------
// trapezoidal_step_ramp_generator_top
// step pulse generator with a symmetric trapezoidal speed ramp
// ----------------------------------------------------------------------------
// timing: a tick without a step and a plain command give their result in the next
// cycle; a move, jog or go-to that starts takes one interval division; a step tick
// takes up to two divisions, a speed change and an interval, on the serial divider.
// one word at a time: the next word is taken once the result has been taken.
// synchronous reset puts all registers at their reset values, no clearing pass.
module trapezoidal_step_ramp_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic        req_direction,
   input  logic [30:0] req_step_count,
   input  logic signed [31:0] req_position_value,
   input  logic [15:0] req_speed_request,
   input  logic        req_limit_min_pressed,
   input  logic        req_limit_max_pressed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_step_level,
   output logic        rsp_dir_level,
   output logic        rsp_busy_res,
   output logic signed [31:0] rsp_abs_position,
   output logic        rsp_accepted,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tsr_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DELTA = 2'd1;
   localparam logic [1:0] ST_INTV  = 2'd2;

   localparam logic [1:0] MODE_ADD_JOG    = 2'd0;
   localparam logic [1:0] MODE_ADD_RAMP   = 2'd1;
   localparam logic [1:0] MODE_LOW_START  = 2'd2;
   localparam logic [1:0] MODE_LOW_CRUISE = 2'd3;

   logic [SPD_IN_W-1:0] start_speed_ff, home_speed_ff, speed_cap_ff;
   logic [RATE_W-1:0]   accel_ff, tick_rate_ff;

   logic [1:0]          st_ff, st_in;
   logic [1:0]          mode_ff, mode_in;
   logic                go_ff, go_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                ok_ff, ok_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    taken_ff, taken_in;
   logic [CNT_W-1:0]    ramp_ff, ramp_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;
   logic [INTV_W-1:0]   intv_ff, intv_in;
   logic [INTV_W-1:0]   tick_ff, tick_in;
   logic [SPD_IN_W-1:0] cruise_ff, cruise_in;
   logic                pulse_ff, pulse_in;
   logic                dir_ff, dir_in;
   logic                brake_ff, brake_in;
   logic                jog_ff, jog_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic               accept;
   logic               run_dir, run_go, run_jog;
   logic [CNT_W-1:0]   run_count, diff, mag;
   logic [INTV_W-1:0]  tc_next, iv;
   logic [CNT_W-1:0]   rem_dec, taken_inc;
   logic [SPEED_W-1:0] top_w, floor_w;
   logic [DIV_W:0]     sum;
   logic [DIV_W-1:0]   speed_ext, q;
   logic [RATE_W-1:0]  lo, hi, clamp_v;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);

   assign div_req.start    = go_ff;
   assign div_req.divisor  = speed_ff;
   assign div_req.dividend = (st_ff == ST_DELTA) ?
                             {accel_ff, {(2 * SPEED_FRAC_BITS){1'b0}}} :
                             DIV_W'({tick_rate_ff, {SPEED_FRAC_BITS{1'b0}}});

   tsr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      st_in        = st_ff;
      mode_in      = mode_ff;
      go_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ok_in        = ok_ff;
      rem_in       = rem_ff;
      taken_in     = taken_ff;
      ramp_in      = ramp_ff;
      pos_in       = pos_ff;
      speed_in     = speed_ff;
      intv_in      = intv_ff;
      tick_in      = tick_ff;
      cruise_in    = cruise_ff;
      pulse_in     = pulse_ff;
      dir_in       = dir_ff;
      brake_in     = brake_ff;
      jog_in       = jog_ff;

      tc_next   = tick_ff + INTV_W'(1);
      rem_dec   = rem_ff - CNT_W'(1);
      taken_inc = taken_ff + CNT_W'(1);
      diff      = req_position_value - pos_ff;
      mag       = diff[CNT_W-1] ? (CNT_W'(0) - diff) : diff;
      run_go    = 1'b0;
      run_jog   = 1'b0;
      run_dir   = req_direction;
      run_count = {1'b0, req_step_count};
      lo        = RATE_W'(to_fixed(start_speed_ff) >> SPEED_FRAC_BITS);
      hi        = RATE_W'(to_fixed(speed_cap_ff) >> SPEED_FRAC_BITS);
      clamp_v   = req_speed_request;
      if (clamp_v < lo) clamp_v = lo;
      if (clamp_v > hi) clamp_v = hi;

      q         = div_rsp.quotient;
      speed_ext = DIV_W'(speed_ff);
      sum       = {1'b0, speed_ext} + {1'b0, q};
      top_w     = (mode_ff == MODE_ADD_JOG) ? to_fixed(home_speed_ff) : to_fixed(cruise_ff);
      floor_w   = (mode_ff == MODE_LOW_START) ? to_fixed(start_speed_ff)
                                              : to_fixed(cruise_ff);
      iv        = q[INTV_W-1:0];
      if (iv < INTV_W'(MIN_INTERVAL)) iv = INTV_W'(MIN_INTERVAL);

      if (accept) begin
         ok_in        = 1'b1;
         rsp_valid_in = 1'b1;
         case (req_operation)
            OP_TICK: begin
               pulse_in = 1'b0;
               if (rem_ff != '0) begin
                  if (tc_next < intv_ff) begin
                     tick_in = tc_next;
                  end else begin
                     tick_in  = '0;
                     pulse_in = 1'b1;
                     taken_in = taken_inc;
                     rem_in   = rem_dec;
                     pos_in   = dir_ff ? pos_ff + CNT_W'(1) : pos_ff - CNT_W'(1);
                     if (jog_ff) begin
                        if (speed_ff < to_fixed(home_speed_ff)) begin
                           st_in   = ST_DELTA;
                           mode_in = MODE_ADD_JOG;
                        end
                     end else if (brake_ff) begin
                        st_in   = ST_DELTA;
                        mode_in = MODE_LOW_START;
                     end else if (speed_ff < to_fixed(cruise_ff)) begin
                        if (rem_dec <= taken_inc) begin
                           brake_in = 1'b1;
                           st_in    = ST_INTV;
                        end else begin
                           st_in   = ST_DELTA;
                           mode_in = MODE_ADD_RAMP;
                        end
                     end else begin
                        if (rem_dec <= ramp_ff) brake_in = 1'b1;
                        if (speed_ff > to_fixed(cruise_ff)) begin
                           st_in   = ST_DELTA;
                           mode_in = MODE_LOW_CRUISE;
                        end else begin
                           st_in = ST_INTV;
                        end
                     end
                  end
               end
            end
            OP_MOVE: run_go = 1'b1;
            OP_JOG: begin
               run_go    = 1'b1;
               run_jog   = 1'b1;
               run_count = JOG_COUNT;
            end
            OP_STOP:   rem_in = '0;
            OP_SETPOS: pos_in = req_position_value;
            OP_GOTO: begin
               if (diff != '0) begin
                  run_go    = 1'b1;
                  run_dir   = !diff[CNT_W-1];
                  run_count = mag;
               end
            end
            OP_SPEED: cruise_in = clamp_v[SPD_IN_W-1:0];
            default: ;
         endcase
         if (run_go) begin
            // limit switch in the direction of travel refuses the command
            if (run_dir ? req_limit_max_pressed : req_limit_min_pressed) begin
               ok_in = 1'b0;
            end else begin
               dir_in = run_dir;
               jog_in = run_jog;
               if (!run_jog) begin
                  taken_in = '0;
                  ramp_in  = '0;
                  brake_in = 1'b0;
               end
               speed_in = to_fixed(start_speed_ff);
               tick_in  = '0;
               rem_in   = run_count;
               st_in    = ST_INTV;
            end
         end
         if (st_in != ST_IDLE) begin
            go_in        = 1'b1;
            rsp_valid_in = 1'b0;
         end
      end else if (div_rsp.done && st_ff == ST_DELTA) begin
         case (mode_ff)
            MODE_ADD_JOG: begin
               speed_in = (sum > (DIV_W + 1)'(top_w)) ? top_w : sum[SPEED_W-1:0];
            end
            MODE_ADD_RAMP: begin
               if (sum >= (DIV_W + 1)'(top_w)) begin
                  speed_in = top_w;
                  ramp_in  = taken_ff;
               end else begin
                  speed_in = sum[SPEED_W-1:0];
               end
            end
            default: begin
               if (q >= speed_ext || (speed_ext - q) < DIV_W'(floor_w)) begin
                  speed_in = floor_w;
               end else begin
                  speed_in = speed_ff - q[SPEED_W-1:0];
               end
            end
         endcase
         st_in = ST_INTV;
         go_in = 1'b1;
      end else if (div_rsp.done && st_ff == ST_INTV) begin
         intv_in      = iv;
         st_in        = ST_IDLE;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_speed_ff <= SPD_IN_W'(150);
         home_speed_ff  <= SPD_IN_W'(800);
         speed_cap_ff   <= SPD_IN_W'(2000);
         accel_ff       <= RATE_W'(1000);
         tick_rate_ff   <= RATE_W'(10000);
         st_ff          <= ST_IDLE;
         mode_ff        <= MODE_ADD_JOG;
         go_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ok_ff          <= 1'b1;
         rem_ff         <= '0;
         taken_ff       <= '0;
         ramp_ff        <= '0;
         pos_ff         <= '0;
         speed_ff       <= '0;
         intv_ff        <= '0;
         tick_ff        <= '0;
         cruise_ff      <= SPD_IN_W'(2000);
         pulse_ff       <= 1'b0;
         dir_ff         <= 1'b1;
         brake_ff       <= 1'b0;
         jog_ff         <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_START_SPEED: start_speed_ff <= csr_wdata[SPD_IN_W-1:0];
               REG_HOME_SPEED:  home_speed_ff  <= csr_wdata[SPD_IN_W-1:0];
               REG_SPEED_CAP:   speed_cap_ff   <= csr_wdata[SPD_IN_W-1:0];
               REG_ACCEL:       accel_ff       <= csr_wdata;
               REG_TICK_RATE:   tick_rate_ff   <= csr_wdata;
               default: ;
            endcase
         end
         st_ff        <= st_in;
         mode_ff      <= mode_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         ok_ff        <= ok_in;
         rem_ff       <= rem_in;
         taken_ff     <= taken_in;
         ramp_ff      <= ramp_in;
         pos_ff       <= pos_in;
         speed_ff     <= speed_in;
         intv_ff      <= intv_in;
         tick_ff      <= tick_in;
         cruise_ff    <= cruise_in;
         pulse_ff     <= pulse_in;
         dir_ff       <= dir_in;
         brake_ff     <= brake_in;
         jog_ff       <= jog_in;
      end
   end

   // result word is read straight from the state, held while no word is taken
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_step_level   = pulse_ff;
   assign rsp_dir_level    = dir_ff;
   assign rsp_busy_res     = (rem_ff != '0);
   assign rsp_abs_position = pos_ff;
   assign rsp_accepted     = ok_ff;

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> st_ff == ST_IDLE) else $error("result shown mid item");
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      go_ff |-> st_ff != ST_IDLE) else $error("divider started while idle");
   a_delta_speed: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DELTA |-> speed_ff != '0) else $error("delta with zero speed");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_IDLE |-> !div_rsp.busy) else $error("divider busy while idle");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the trapezoidal step ramp generator: a clocked
// driver and monitor with random gaps and stalls, a word-level predictor of
// speed, interval, position and limit handling, and several register settings
// ----------------------------------------------------------------------------
module tb;
   import tsr_pkg::*;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 120;

   typedef struct {
      logic [2:0]         op;
      logic               dir;
      logic [30:0]        count;
      logic signed [31:0] pos;
      logic [15:0]        speed_req;
      logic               lmin;
      logic               lmax;
   } word_type;

   typedef struct {
      logic               step;
      logic               dir;
      logic               busy;
      logic signed [31:0] pos;
      logic               ok;
   } pin_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_operation = OP_TICK;
   logic req_direction = 1'b0;
   logic [30:0] req_step_count = '0;
   logic signed [31:0] req_position_value = '0;
   logic [15:0] req_speed_request = '0;
   logic req_limit_min_pressed = 1'b0;
   logic req_limit_max_pressed = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_step_level, rsp_dir_level, rsp_busy_res, rsp_accepted;
   logic signed [31:0] rsp_abs_position;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = REG_START_SPEED;
   logic [15:0] csr_wdata = '0;

   trapezoidal_step_ramp_generator_top u_dut (.*);

   // register copies and motion state of the predictor
   logic [12:0] c_start = 13'd150, c_home = 13'd800, c_cap = 13'd2000;
   logic [15:0] c_accel = 16'd1000, c_rate = 16'd10000;
   logic [31:0] m_remaining = '0, m_taken = '0, m_ramp = '0, m_pos = '0;
   logic [63:0] m_speed = '0, m_interval = '0;
   logic [23:0] m_tick = '0;
   logic [12:0] m_cruise = 13'd2000;
   logic m_pulse = 1'b0, m_dir = 1'b1, m_brake = 1'b0, m_jog = 1'b0;

   word_type      pending_words[$];
   pin_state_type expected_pins[$];
   word_type      cur;
   int gap = 0, stall_left = 0, cycles = 0, errors = 0;
   int words_taken = 0, pins_checked = 0, steps_seen = 0, refusals = 0;
   bit no_idle = 1'b0;

   initial forever #10 clock = ~clock;

   function automatic logic [63:0] q8_of(logic [12:0] v);
      return {51'd0, (v == 13'd0) ? 13'd1 : v} << 8;
   endfunction

   function automatic logic [63:0] speed_change();
      logic [63:0] num;
      num = {48'd0, c_accel} << 16;
      return (m_speed != 0) ? num / m_speed : num;
   endfunction

   function automatic void recalc_interval();
      logic [63:0] num, iv;
      num = {48'd0, c_rate} << 8;
      iv = (m_speed != 0) ? num / m_speed : num;
      if (iv < MIN_INTERVAL) iv = MIN_INTERVAL;
      m_interval = iv;
   endfunction

   function automatic void slow_to(logic [63:0] floor);
      logic [63:0] d;
      d = speed_change();
      if (d >= m_speed || m_speed - d < floor) m_speed = floor;
      else m_speed = m_speed - d;
   endfunction

   function automatic void begin_run(logic dir, logic [31:0] count, logic jog);
      m_dir = dir;
      m_jog = jog;
      if (!jog) begin
         m_taken = '0;
         m_ramp = '0;
         m_brake = 1'b0;
      end
      m_speed = q8_of(c_start);
      recalc_interval();
      m_tick = '0;
      m_remaining = count;
   endfunction

   function automatic void advance_tick();
      logic [63:0] top;
      m_pulse = 1'b0;
      if (m_remaining == 0) return;
      m_tick = m_tick + 24'd1;
      if ({40'd0, m_tick} < m_interval) return;
      m_tick = '0;
      m_pulse = 1'b1;
      m_taken = m_taken + 1;
      m_remaining = m_remaining - 1;
      m_pos = m_dir ? m_pos + 1 : m_pos - 1;
      if (m_jog) begin
         top = q8_of(c_home);
         if (m_speed < top) begin
            m_speed = m_speed + speed_change();
            if (m_speed > top) m_speed = top;
            recalc_interval();
         end
         return;
      end
      top = q8_of(m_cruise);
      if (m_brake) begin
         slow_to(q8_of(c_start));
      end else if (m_speed < top) begin
         if (m_remaining <= m_taken) begin
            m_brake = 1'b1;
         end else begin
            m_speed = m_speed + speed_change();
            if (m_speed >= top) begin
               m_speed = top;
               m_ramp = m_taken;
            end
         end
      end else begin
         if (m_speed > top) slow_to(top);
         if (m_remaining <= m_ramp) m_brake = 1'b1;
      end
      recalc_interval();
   endfunction

   function automatic pin_state_type predict_pins(word_type w);
      pin_state_type p;
      logic [31:0] diff, mag, lo, hi, v;
      logic ok, up;
      ok = 1'b1;
      case (w.op)
         OP_TICK: advance_tick();
         OP_MOVE: begin
            if (w.dir ? w.lmax : w.lmin) ok = 1'b0;
            else begin_run(w.dir, {1'b0, w.count}, 1'b0);
         end
         OP_JOG: begin
            if (w.dir ? w.lmax : w.lmin) ok = 1'b0;
            else begin_run(w.dir, JOG_COUNT, 1'b1);
         end
         OP_STOP: m_remaining = '0;
         OP_SETPOS: m_pos = w.pos;
         OP_GOTO: begin
            diff = w.pos - m_pos;
            if (diff != 0) begin
               up = ~diff[31];
               mag = up ? diff : -diff;
               if (up ? w.lmax : w.lmin) ok = 1'b0;
               else begin_run(up, mag, 1'b0);
            end
         end
         OP_SPEED: begin
            lo = (c_start == 0) ? 32'd1 : {19'd0, c_start};
            hi = (c_cap == 0) ? 32'd1 : {19'd0, c_cap};
            v = {16'd0, w.speed_req};
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            m_cruise = v[12:0];
         end
         default: ;
      endcase
      p.step = m_pulse;
      p.dir = m_dir;
      p.busy = (m_remaining != 0);
      p.pos = m_pos;
      p.ok = ok;
      return p;
   endfunction

   function automatic int draw_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report(string field, longint got, longint want);
      errors++;
      $display("mismatch %0s: got %0d expected %0d (word %0d)", field, got, want, pins_checked);
   endtask

   // sender side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_pins.push_back(predict_pins(cur));
            words_taken++;
         end
         if (req_valid && req_stall) begin
            // word held while stalled
         end else if (gap != 0) begin
            req_valid <= 1'b0;
            gap <= gap - 1;
         end else if (pending_words.size() > 0) begin
            cur = pending_words.pop_front();
            req_operation <= cur.op;
            req_direction <= cur.dir;
            req_step_count <= cur.count;
            req_position_value <= cur.pos;
            req_speed_request <= cur.speed_req;
            req_limit_min_pressed <= cur.lmin;
            req_limit_max_pressed <= cur.lmax;
            req_valid <= 1'b1;
            gap <= draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver side
   always @(posedge clock) begin
      pin_state_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pins.size() == 0) begin
               report("unexpected word", 0, 0);
            end else begin
               e = expected_pins.pop_front();
               if (rsp_step_level !== e.step) report("step_level", rsp_step_level, e.step);
               if (rsp_dir_level !== e.dir) report("dir_level", rsp_dir_level, e.dir);
               if (rsp_busy_res !== e.busy) report("busy_res", rsp_busy_res, e.busy);
               if (rsp_abs_position !== e.pos)
                  report("abs_position", rsp_abs_position, e.pos);
               if (rsp_accepted !== e.ok) report("accepted", rsp_accepted, e.ok);
               if (e.step) steps_seen++;
               if (!e.ok) refusals++;
            end
            pins_checked++;
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left <= draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** trapezoidal_step_ramp_generator_top: FAILED **");
         $finish;
      end
   end

   task automatic queue_word(logic [2:0] op, logic dir, logic [30:0] count,
                             logic [31:0] pos, logic [15:0] sreq, logic lmin, logic lmax);
      word_type w;
      w.op = op; w.dir = dir; w.count = count; w.pos = pos;
      w.speed_req = sreq; w.lmin = lmin; w.lmax = lmax;
      pending_words.push_back(w);
   endtask

   task automatic queue_random_word();
      int r;
      logic [30:0] cnt;
      logic [31:0] pos;
      r = $urandom_range(0, 99);
      cnt = $urandom_range(0, 99) < 90 ? 31'($urandom_range(0, 40)) : 31'($urandom);
      pos = $urandom_range(0, 3) == 0 ? $urandom : m_pos + $urandom_range(0, 60) - 30;
      queue_word(r < 70 ? OP_TICK : r < 78 ? OP_MOVE : r < 81 ? OP_JOG : r < 85 ? OP_STOP :
                 r < 88 ? OP_SETPOS : r < 93 ? OP_GOTO : r < 98 ? OP_SPEED : OP_UNUSED,
                 1'($urandom_range(0, 1)), cnt, pos,
                 $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3000)),
                 $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_pins.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_START_SPEED: c_start = val[12:0];
         REG_HOME_SPEED: c_home = val[12:0];
         REG_SPEED_CAP: c_cap = val[12:0];
         REG_ACCEL: c_accel = val;
         REG_TICK_RATE: c_rate = val;
         default: ;
      endcase
   endtask

   task automatic load_setting(logic [15:0] s, logic [15:0] h, logic [15:0] c,
                               logic [15:0] a, logic [15:0] t);
      write_reg(REG_START_SPEED, s);
      write_reg(REG_HOME_SPEED, h);
      write_reg(REG_SPEED_CAP, c);
      write_reg(REG_ACCEL, a);
      write_reg(REG_TICK_RATE, t);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      static logic [15:0] setting[6][5] = '{
         '{16'd100, 16'd300, 16'd800, 16'd2000, 16'd400},
         '{16'd1, 16'd5000, 16'd5000, 16'd65535, 16'd1},
         '{16'd5000, 16'd1, 16'd1, 16'd1, 16'd65535},
         '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
         '{16'd200, 16'd600, 16'd1500, 16'd8000, 16'd1000},
         '{16'hE010, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000}};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      load_setting(16'd20, 16'd60, 16'd400, 16'd3000, 16'd200);
      // directed: refusals, wrap, go-to corner cases, odd operations
      queue_word(OP_MOVE, 1'b1, 31'd3, '0, '0, 1'b0, 1'b0);
      repeat (6) queue_word(OP_TICK, 1'b0, '0, '0, '0, 1'b1, 1'b1);
      queue_word(OP_STOP, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      queue_word(OP_SETPOS, 1'b0, '0, 32'h7FFF_FFFF, '0, 1'b0, 1'b0);
      queue_word(OP_MOVE, 1'b1, 31'h7FFF_FFFF, '0, '0, 1'b0, 1'b1);
      queue_word(OP_MOVE, 1'b0, 31'd5, '0, '0, 1'b1, 1'b0);
      queue_word(OP_JOG, 1'b1, '0, '0, '0, 1'b0, 1'b1);
      queue_word(OP_MOVE, 1'b1, 31'd1, '0, '0, 1'b1, 1'b0);
      repeat (12) queue_word(OP_TICK, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      queue_word(OP_GOTO, 1'b0, '0, 32'h8000_0000, '0, 1'b1, 1'b1);
      queue_word(OP_GOTO, 1'b0, '0, 32'h0000_0000, '0, 1'b1, 1'b0);
      queue_word(OP_GOTO, 1'b0, '0, 32'h0000_0000, '0, 1'b0, 1'b0);
      queue_word(OP_SPEED, 1'b0, '0, '0, 16'd0, 1'b0, 1'b0);
      queue_word(OP_SPEED, 1'b0, '0, '0, 16'hFFFF, 1'b0, 1'b0);
      queue_word(OP_UNUSED, 1'b1, 31'h5555_5555, 32'hAAAA_AAAA, 16'h5A5A, 1'b1, 1'b1);
      queue_word(OP_MOVE, 1'b0, 31'd0, '0, '0, 1'b0, 1'b0);
      queue_word(OP_JOG, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      repeat (8) queue_word(OP_TICK, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      queue_word(OP_STOP, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      wait_idle();
      for (int p = 0; p < 6; p++) begin
         load_setting(setting[p][0], setting[p][1], setting[p][2], setting[p][3],
                      setting[p][4]);
         no_idle = (p == 4);
         for (int n = 0; n < 85; n++) begin
            queue_random_word();
            // let the queue drain a little so go-to targets track the position
            if (n % 8 == 7) while (pending_words.size() > 2) @(posedge clock);
         end
         wait_idle();
      end
      $display("covered %0d words over seven register settings: %0d steps, %0d refusals",
               words_taken, steps_seen, refusals);
      $display("%0d mismatches in %0d checked results", errors, pins_checked);
      if (errors == 0) begin
         $display("** trapezoidal_step_ramp_generator_top: PASSED **");
      end else begin
         $display("** trapezoidal_step_ramp_generator_top: FAILED **");
      end
      $finish;
   end

endmodule
